/* hdl/fltw_pkg.sv */
// Package: shared types, codes and helpers for the four-level table walker.
package fltw_pkg;

  // Fixed geometry of one table and of one entry
  localparam int unsigned ENTRIES_PER_TABLE = 512;
  localparam int unsigned IDX_W             = 9;
  localparam int unsigned ENTRY_W           = 64;
  localparam int unsigned FRAME_LSB         = 12;
  localparam int unsigned FRAME_MSB         = 50;
  localparam int unsigned FRAME_W           = FRAME_MSB - FRAME_LSB + 1;
  localparam int unsigned VA_W              = 48;
  localparam int unsigned VPN_W             = VA_W - FRAME_LSB;
  localparam int unsigned ROOT_W            = 7;
  localparam int unsigned WORD_W            = 16;
  localparam int unsigned LEVEL_W           = 2;
  localparam int unsigned OP_W              = 2;
  localparam int unsigned CMD_W             = 2;

  // Entry flag bit positions
  localparam int unsigned BIT_PRESENT    = 0;
  localparam int unsigned BIT_WRITABLE   = 1;
  localparam int unsigned BIT_SUPERVISOR = 2;
  localparam int unsigned BIT_NOEXEC     = 63;

  // Top level of the walk
  localparam logic [LEVEL_W-1:0] TOP_LEVEL = 2'd3;

  // Command codes; the unused code behaves as a read walk
  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE  = 2'd0,
    CMD_READ   = 2'd1,
    CMD_UPDATE = 2'd2
  } cmd_e;

  // Flag operation codes; the unused code keeps the bit
  typedef enum logic [OP_W-1:0] {
    OP_KEEP  = 2'd0,
    OP_SET   = 2'd1,
    OP_CLEAR = 2'd2
  } flag_op_e;

  typedef enum logic [OP_W-1:0] {
    EX_KEEP       = 2'd0,
    EX_EXECUTABLE = 2'd1,
    EX_NO_EXECUTE = 2'd2
  } exec_op_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_CHECK,
    ST_READ,
    ST_DONE
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load_in;     // capture an input beat, start at root frame
    logic do_write;    // perform the table word write, set result
    logic walk_oor;    // walk left the store, set out-of-range result
    logic issue_read;  // read entry at current frame and level
    logic step_down;   // follow frame bits of the entry just read
    logic finish;      // target entry read: update if asked, set result
    logic out_load;    // move result into the output register
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_is_write; // incoming beat carries a write command
    logic frame_oor;   // current frame lies beyond the store
    logic at_level;    // current level is the requested one
  } dp_sts_t;

  // Set, clear or keep one flag bit
  function automatic logic [ENTRY_W-1:0] apply_flag(input logic [ENTRY_W-1:0] v,
                                                   input logic [OP_W-1:0] op,
                                                   input logic [5:0] pos);
    logic [ENTRY_W-1:0] r;
    r = v;
    case (op)
      OP_SET:   r[pos] = 1'b1;
      OP_CLEAR: r[pos] = 1'b0;
      default:  r = v;
    endcase
    return r;
  endfunction

  // No-execute bit: executable clears it, no-execute sets it
  function automatic logic [ENTRY_W-1:0] apply_exec(input logic [ENTRY_W-1:0] v,
                                                   input logic [OP_W-1:0] op);
    logic [ENTRY_W-1:0] r;
    r = v;
    case (op)
      EX_EXECUTABLE: r[BIT_NOEXEC] = 1'b0;
      EX_NO_EXECUTE: r[BIT_NOEXEC] = 1'b1;
      default:       r = v;
    endcase
    return r;
  endfunction

endpackage

/* hdl/four_level_page_table_walker_core.sv */
// Top level: four-level page table walker over an on-chip table store.
//
// Input beats arrive on the s_axis channel: tuser carries the command (write
// table word, walk and read, walk and update flags), tdata the address, stop
// level, table word index, write data and four flag operations. Each beat
// gives exactly one result beat on m_axis: entry index and value in tdata,
// the out-of-range flag in tuser. The cfg channel loads the 7-bit root frame
// and is always ready; write it only while the walker is idle.
// A table word write passes through a write state and a done state; a walk
// passes through a frame check state and a registered read of the table store
// for each level from the top down to the stop level, ending early when a
// frame leaves the store, and then the done state. A new beat is accepted
// in the cycle after the result moves to the output register, so one beat is
// in work at a time while the previous result waits.
// When m_axis stalls, a finished result waits in the walker until the output
// register frees up. Reset clears the controller, the output valid and the
// root frame; the table store contents are undefined until written.
module four_level_page_table_walker_core #(
  parameter int unsigned TABLE_PAGES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Configuration: root frame
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [6:0]   cfg_data_i,
  // Input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [47:0] address, [49:48] level, [65:50] table_word, [129:66] data,
  // [131:130] present_op, [133:132] writable_op, [135:134] supervisor_op,
  // [137:136] exec_op, [143:138] zero
  input  logic [143:0] s_axis_tdata,
  // [1:0] cmd
  input  logic [1:0]   s_axis_tuser,
  // Result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] entry_index, [79:16] entry_value
  output logic [79:0]  m_axis_tdata,
  // [0] out_of_range
  output logic         m_axis_tuser
);

  fltw_pkg::dp_cmd_t dp_cmd;
  fltw_pkg::dp_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  fltw_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .sts_i         (dp_sts),
    .cmd_o         (dp_cmd)
  );

  fltw_dp #(
    .TABLE_PAGES (TABLE_PAGES)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cmd_i        (dp_cmd),
    .sts_o        (dp_sts)
  );

endmodule

/* hdl/fltw_ctrl.sv */
// Controller state machine sequencing writes and table walks.
module fltw_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  fltw_pkg::dp_sts_t  sts_i,
  output fltw_pkg::dp_cmd_t  cmd_o
);

  fltw_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             in_accept;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == fltw_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fltw_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_d = sts_i.in_is_write ? fltw_pkg::ST_WRITE : fltw_pkg::ST_CHECK;
        end
      end
      fltw_pkg::ST_WRITE: state_d = fltw_pkg::ST_DONE;
      fltw_pkg::ST_CHECK: begin
        state_d = sts_i.frame_oor ? fltw_pkg::ST_DONE : fltw_pkg::ST_READ;
      end
      fltw_pkg::ST_READ: begin
        state_d = sts_i.at_level ? fltw_pkg::ST_DONE : fltw_pkg::ST_CHECK;
      end
      fltw_pkg::ST_DONE: begin
        if (out_free) begin
          state_d = fltw_pkg::ST_IDLE;
        end
      end
      default: state_d = fltw_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands
  always_comb begin
    cmd_o = '0;
    case (state_q)
      fltw_pkg::ST_IDLE:  cmd_o.load_in  = in_accept;
      fltw_pkg::ST_WRITE: cmd_o.do_write = 1'b1;
      fltw_pkg::ST_CHECK: begin
        cmd_o.walk_oor   = sts_i.frame_oor;
        cmd_o.issue_read = !sts_i.frame_oor;
      end
      fltw_pkg::ST_READ: begin
        cmd_o.finish    = sts_i.at_level;
        cmd_o.step_down = !sts_i.at_level;
      end
      fltw_pkg::ST_DONE:  cmd_o.out_load = out_free;
      default:            cmd_o = '0;
    endcase
  end

  // Output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fltw_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Checks
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result load did not raise output valid");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != fltw_pkg::ST_IDLE)
    else $error("accepted beat did not start work");

  a_descend_rechecks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step_down |=> state_q == fltw_pkg::ST_CHECK)
    else $error("walk step did not return to frame check");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command in a cycle");

endmodule

/* hdl/fltw_dp.sv */
// Datapath: table store, walk registers, flag update and result registers.
module fltw_dp #(
  parameter int unsigned TABLE_PAGES = 128
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [fltw_pkg::ROOT_W-1:0]       cfg_data_i,
  input  logic [143:0]                      s_axis_tdata,
  input  logic [fltw_pkg::CMD_W-1:0]        s_axis_tuser,
  output logic [79:0]                       m_axis_tdata,
  output logic                              m_axis_tuser,
  input  fltw_pkg::dp_cmd_t                 cmd_i,
  output fltw_pkg::dp_sts_t                 sts_o
);

  localparam int unsigned PW    = $clog2(TABLE_PAGES);
  localparam int unsigned AW    = PW + fltw_pkg::IDX_W;
  localparam int unsigned DEPTH = TABLE_PAGES * fltw_pkg::ENTRIES_PER_TABLE;
  localparam logic [31:0] STORE_WORDS = 32'(DEPTH);
  localparam logic [fltw_pkg::FRAME_W-1:0] PAGES_LIM = fltw_pkg::FRAME_W'(TABLE_PAGES);

  // Table store
  logic [fltw_pkg::ENTRY_W-1:0] table_mem [DEPTH];

  // Configuration and captured item
  logic [fltw_pkg::ROOT_W-1:0]  root_frame_q;
  logic [fltw_pkg::CMD_W-1:0]   cmd_q;
  logic [fltw_pkg::VPN_W-1:0]   vpn_q;
  logic [fltw_pkg::LEVEL_W-1:0] level_q;
  logic [fltw_pkg::WORD_W-1:0]  word_q;
  logic [fltw_pkg::ENTRY_W-1:0] data_q;
  logic [fltw_pkg::OP_W-1:0]    present_op_q, writable_op_q, supervisor_op_q, exec_op_q;

  // Walk state
  logic [fltw_pkg::FRAME_W-1:0] frame_q;
  logic [fltw_pkg::LEVEL_W-1:0] lvl_q;
  logic [AW-1:0]                idx_q;
  logic [fltw_pkg::ENTRY_W-1:0] rd_data_q;

  // Result and output registers
  logic [fltw_pkg::WORD_W-1:0]  res_index_q;
  logic [fltw_pkg::ENTRY_W-1:0] res_value_q;
  logic                         res_oor_q;
  logic [fltw_pkg::WORD_W-1:0]  out_index_q;
  logic [fltw_pkg::ENTRY_W-1:0] out_value_q;
  logic                         out_oor_q;

  logic [fltw_pkg::IDX_W-1:0]   vidx;
  logic [AW-1:0]                rd_addr;
  logic [31:0]                  word_ext;
  logic [31:0]                  idx_ext;
  logic                         word_ok;
  logic                         is_update;
  logic [fltw_pkg::ENTRY_W-1:0] upd_val;
  logic                         mem_we;
  logic [AW-1:0]                mem_wa;
  logic [fltw_pkg::ENTRY_W-1:0] mem_wd;

  // Index slice of the virtual page number for the current level
  always_comb begin
    case (lvl_q)
      2'd0:    vidx = vpn_q[8:0];
      2'd1:    vidx = vpn_q[17:9];
      2'd2:    vidx = vpn_q[26:18];
      default: vidx = vpn_q[35:27];
    endcase
  end

  assign rd_addr   = {frame_q[PW-1:0], vidx};
  assign word_ext  = 32'(word_q);
  assign idx_ext   = 32'(idx_q);
  assign word_ok   = word_ext < STORE_WORDS;
  assign is_update = (cmd_q == fltw_pkg::CMD_UPDATE);

  // Flag update of the target entry
  always_comb begin
    upd_val = fltw_pkg::apply_flag(rd_data_q, present_op_q, 6'(fltw_pkg::BIT_PRESENT));
    upd_val = fltw_pkg::apply_flag(upd_val, writable_op_q, 6'(fltw_pkg::BIT_WRITABLE));
    upd_val = fltw_pkg::apply_flag(upd_val, supervisor_op_q,
                                   6'(fltw_pkg::BIT_SUPERVISOR));
    upd_val = fltw_pkg::apply_exec(upd_val, exec_op_q);
  end

  // Memory write port: table word write or flag write-back
  always_comb begin
    mem_we = 1'b0;
    mem_wa = idx_q;
    mem_wd = upd_val;
    if (cmd_i.do_write && word_ok) begin
      mem_we = 1'b1;
      mem_wa = word_ext[AW-1:0];
      mem_wd = data_q;
    end else if (cmd_i.finish && is_update) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[mem_wa] <= mem_wd;
    end
  end

  // Memory read port, registered
  always_ff @(posedge clk_i) begin
    if (cmd_i.issue_read) begin
      rd_data_q <= table_mem[rd_addr];
    end
  end

  // Root frame register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      root_frame_q <= '0;
    end else if (cfg_valid_i) begin
      root_frame_q <= cfg_data_i;
    end
  end

  // Item capture and walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      cmd_q           <= s_axis_tuser;
      vpn_q           <= s_axis_tdata[47:12];
      level_q         <= s_axis_tdata[49:48];
      word_q          <= s_axis_tdata[65:50];
      data_q          <= s_axis_tdata[129:66];
      present_op_q    <= s_axis_tdata[131:130];
      writable_op_q   <= s_axis_tdata[133:132];
      supervisor_op_q <= s_axis_tdata[135:134];
      exec_op_q       <= s_axis_tdata[137:136];
      frame_q         <= fltw_pkg::FRAME_W'(root_frame_q);
      lvl_q           <= fltw_pkg::TOP_LEVEL;
    end
    if (cmd_i.issue_read) begin
      idx_q <= rd_addr;
    end
    if (cmd_i.step_down) begin
      frame_q <= rd_data_q[fltw_pkg::FRAME_MSB:fltw_pkg::FRAME_LSB];
      lvl_q   <= lvl_q - 2'd1;
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.do_write) begin
      res_index_q <= word_q;
      res_value_q <= word_ok ? data_q : '0;
      res_oor_q   <= !word_ok;
    end
    if (cmd_i.walk_oor) begin
      res_index_q <= '0;
      res_value_q <= '0;
      res_oor_q   <= 1'b1;
    end
    if (cmd_i.finish) begin
      res_index_q <= idx_ext[fltw_pkg::WORD_W-1:0];
      res_value_q <= is_update ? upd_val : rd_data_q;
      res_oor_q   <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_index_q <= res_index_q;
      out_value_q <= res_value_q;
      out_oor_q   <= res_oor_q;
    end
  end

  assign m_axis_tdata = {out_value_q, out_index_q};
  assign m_axis_tuser = out_oor_q;

  assign sts_o.in_is_write = (s_axis_tuser == fltw_pkg::CMD_WRITE);
  assign sts_o.frame_oor   = (frame_q >= PAGES_LIM);
  assign sts_o.at_level    = (lvl_q == level_q);

endmodule

/* test/fltw_walk_checker.sv */
// Checker for the four-level table walker: predicts each result beat and compares it.
module fltw_walk_checker
  import fltw_pkg::*;
#(
  parameter int unsigned TABLE_PAGES = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_valid_i,
  input  logic         cfg_ready_i,
  input  logic [6:0]   cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_i,
  // [47:0] address, [49:48] level, [65:50] table_word, [129:66] data,
  // [131:130] present_op, [133:132] writable_op, [135:134] supervisor_op,
  // [137:136] exec_op, [143:138] zero
  input  logic [143:0] s_tdata_i,
  // [1:0] cmd
  input  logic [1:0]   s_tuser_i,
  input  logic         m_tvalid_i,
  input  logic         m_tready_i,
  // [15:0] entry_index, [79:16] entry_value
  input  logic [79:0]  m_tdata_i,
  // [0] out_of_range
  input  logic         m_tuser_i,
  output int unsigned  pending_o,
  output int unsigned  fail_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STORE_WORDS = TABLE_PAGES * ENTRIES_PER_TABLE;
  localparam int unsigned REPORT_MAX  = 10;

  typedef struct packed {
    logic [WORD_W-1:0]  index;
    logic [ENTRY_W-1:0] value;
    logic               oor;
  } entry_result_t;

  // Own copy of the table store and the root frame register
  logic [ENTRY_W-1:0] store_copy [STORE_WORDS];
  logic [ROOT_W-1:0]  root_frame_q;
  entry_result_t      entry_results_q [$];
  entry_result_t      want, got;

  // Set, clear or keep one flag bit
  function automatic logic [ENTRY_W-1:0] flag_update(input logic [ENTRY_W-1:0] v,
                                                     input logic [OP_W-1:0] op,
                                                     input int unsigned pos);
    logic [ENTRY_W-1:0] r;
    r = v;
    if (op == OP_SET) r[pos] = 1'b1;
    else if (op == OP_CLEAR) r[pos] = 1'b0;
    return r;
  endfunction

  // Expected result of one input beat; writes and updates land in the store copy
  function automatic entry_result_t predict_entry(input logic [CMD_W-1:0] cmd,
                                                  input logic [143:0] beat);
    logic [VPN_W-1:0]   vpn;
    logic [LEVEL_W-1:0] stop;
    logic [LEVEL_W-1:0] lvl;
    logic [WORD_W-1:0]  word;
    logic [FRAME_W-1:0] frame;
    logic [ENTRY_W-1:0] v;
    logic [47:0]        idx;
    logic               hit;
    entry_result_t      r;
    vpn  = beat[VA_W-1:FRAME_LSB];
    stop = beat[49:48];
    word = beat[65:50];
    r    = '0;
    idx  = '0;
    if (cmd == CMD_WRITE) begin
      r.index = word;
      if (word < STORE_WORDS) begin
        store_copy[word] = beat[129:66];
        r.value = beat[129:66];
      end else begin
        r.oor = 1'b1;
      end
      return r;
    end
    // Walk down from the top table to the requested level
    frame = FRAME_W'(root_frame_q);
    lvl   = TOP_LEVEL;
    hit   = 1'b0;
    while (!hit && !r.oor) begin
      if (frame >= TABLE_PAGES) begin
        r.oor = 1'b1;
      end else begin
        idx = 48'(frame) * ENTRIES_PER_TABLE + 48'(vpn[IDX_W*lvl +: IDX_W]);
        if (lvl == stop) begin
          hit = 1'b1;
        end else begin
          frame = store_copy[idx][FRAME_MSB:FRAME_LSB];
          lvl   = lvl - 1'b1;
        end
      end
    end
    if (r.oor) return r;
    v = store_copy[idx];
    // Flag update and write-back; any other command only reads
    if (cmd == CMD_UPDATE) begin
      v = flag_update(v, beat[131:130], BIT_PRESENT);
      v = flag_update(v, beat[133:132], BIT_WRITABLE);
      v = flag_update(v, beat[135:134], BIT_SUPERVISOR);
      if (beat[137:136] == EX_EXECUTABLE) v[BIT_NOEXEC] = 1'b0;
      else if (beat[137:136] == EX_NO_EXECUTE) v[BIT_NOEXEC] = 1'b1;
      store_copy[idx] = v;
    end
    r.index = idx[WORD_W-1:0];
    r.value = v;
    return r;
  endfunction

  task automatic note_mismatch(input string field, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
    if (fail_count_o < REPORT_MAX)
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, exp_v, act_v);
    fail_count_o++;
  endtask

  // Watch config, input and result channels at each rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      root_frame_q = '0;
      entry_results_q.delete();
      pending_o    = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) root_frame_q = cfg_data_i;
      if (s_tvalid_i && s_tready_i) begin
        entry_results_q.push_back(predict_entry(s_tuser_i, s_tdata_i));
        pending_o++;
      end
      if (m_tvalid_i && m_tready_i) begin
        got.index = m_tdata_i[15:0];
        got.value = m_tdata_i[79:16];
        got.oor   = m_tuser_i;
        if (entry_results_q.size() == 0) begin
          if (fail_count_o < REPORT_MAX)
            $display("%0t: result beat with nothing outstanding, index %h value %h oor %b",
                     $time, got.index, got.value, got.oor);
          fail_count_o++;
        end else begin
          want = entry_results_q.pop_front();
          pending_o--;
          if (got.index !== want.index) note_mismatch("entry_index", want.index, got.index);
          if (got.value !== want.value) note_mismatch("entry_value", want.value, got.value);
          if (got.oor !== want.oor) note_mismatch("out_of_range", want.oor, got.oor);
        end
      end
    end
  end

endmodule

/* test/four_level_page_table_walker_core_test.sv */
// Testbench top: stimulus, idling and verdict for the four-level table walker.
module four_level_page_table_walker_core_test;
  import fltw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TABLE_PAGES  = 128;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_BEATS = 820;
  localparam int unsigned PHASES       = 4;
  // Unassigned codes: the walker treats them as a read walk and as keep
  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [OP_W-1:0]  OP_SPARE  = 2'd3;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [6:0]   cfg_data;
  logic         s_tvalid;
  logic         s_tready;
  logic [143:0] s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready = 1'b1;
  logic [79:0]  m_tdata;
  logic         m_tuser;
  int unsigned  pending;
  int unsigned  fail_count;
  int unsigned  cycles;
  int unsigned  idle_pct;
  int unsigned  stall_pct;
  int unsigned  sent;
  int unsigned  phase_start;
  int unsigned  idle_by_phase [PHASES] = '{0, 49, 0, 10};
  int unsigned  stall_by_phase [PHASES] = '{0, 0, 49, 10};

  // Table layout as loaded so far; flag updates never touch the frame bits
  bit [63:0]    layout_words [65536];
  bit           layout_written [65536];
  logic [6:0]   cur_root;

  four_level_page_table_walker_core #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_tdata),
    .m_axis_tuser (m_tuser)
  );

  fltw_walk_checker #(
    .TABLE_PAGES(TABLE_PAGES)
  ) u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tdata_i   (s_tdata),
    .s_tuser_i   (s_tuser),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tdata_i   (m_tdata),
    .m_tuser_i   (m_tuser),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Result-side back-pressure
  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("four_level_page_table_walker_core_test failed");
    $finish;
  end

  // One input beat; returns just after the accepting edge with tvalid still high
  task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [47:0] va,
                           input logic [1:0] lvl, input logic [15:0] word,
                           input logic [63:0] wdata, input logic [7:0] flag_ops);
    // flag_ops: {exec, supervisor, writable, present}
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {6'b0, flag_ops, wdata, word, lvl, va};
    do @(posedge clk_i); while (!s_tready);
    sent++;
  endtask

  // Park the input side and wait until every result has come back
  task automatic quiesce();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_root(input logic [6:0] value);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    cur_root = value;
  endtask

  function automatic logic [47:0] noise_va();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[47:0];
  endfunction

  task automatic load_word(input logic [15:0] word, input logic [63:0] value);
    send_beat(CMD_WRITE, noise_va(), 2'($urandom_range(0, 3)), word, value,
              8'($urandom_range(0, 255)));
    layout_words[word]   = value;
    layout_written[word] = 1'b1;
  endtask

  // Table index, biased toward a few values so tables get shared
  function automatic logic [IDX_W-1:0] pick_index();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      5:       return 9'($urandom_range(0, 511));
      default: return 9'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [47:0] pick_va();
    logic [47:0] va;
    va = noise_va();
    if ($urandom_range(0, 9) < 7)
      for (int l = 0; l < 4; l++) va[FRAME_LSB + IDX_W*l +: IDX_W] = pick_index();
    return va;
  endfunction

  // Entry value with random flags; the frame is mostly small, sometimes off the store
  function automatic logic [63:0] pick_entry();
    logic [63:0] e;
    logic [63:0] far;
    e   = {$urandom(), $urandom()};
    far = {$urandom(), $urandom()};
    case ($urandom_range(0, 19))
      0, 1, 2: e[FRAME_MSB:FRAME_LSB] = far[FRAME_W-1:0] |
                                         (39'd1 << $urandom_range(7, FRAME_W - 1));
      3:       e[FRAME_MSB:FRAME_LSB] = 39'd127;
      4, 5:    e[FRAME_MSB:FRAME_LSB] = 39'($urandom_range(0, 127));
      default: e[FRAME_MSB:FRAME_LSB] = 39'($urandom_range(0, 3));
    endcase
    return e;
  endfunction

  function automatic logic [CMD_W-1:0] pick_walk_cmd();
    case ($urandom_range(0, 19))
      0, 1:    return CMD_SPARE;
      default: return ($urandom_range(0, 1) != 0) ? CMD_UPDATE : CMD_READ;
    endcase
  endfunction

  // Load every entry the walk will read that is still unwritten, then walk
  task automatic walk(input logic [CMD_W-1:0] cmd, input logic [47:0] va,
                      input logic [1:0] lvl, input logic [7:0] flag_ops);
    logic [FRAME_W-1:0] frame;
    logic [15:0]        idx;
    frame = FRAME_W'(cur_root);
    for (int l = 3; l >= int'(lvl); l--) begin
      if (frame >= TABLE_PAGES) break;
      idx = {frame[6:0], va[FRAME_LSB + IDX_W*l +: IDX_W]};
      if (!layout_written[idx]) load_word(idx, pick_entry());
      frame = layout_words[idx][FRAME_MSB:FRAME_LSB];
    end
    send_beat(cmd, va, lvl, 16'($urandom_range(0, 65535)), {$urandom(), $urandom()},
              flag_ops);
  endtask

  task automatic random_op();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 12)
      load_word(16'($urandom_range(0, 65535)), pick_entry());
    else if (pick < 17)
      load_word(16'($urandom_range(0, 65535)), {$urandom(), $urandom()});
    else
      walk(pick_walk_cmd(), pick_va(), 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni    = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = '0;
    idle_pct  = 0;
    stall_pct = 0;
    sent      = 0;
    cur_root  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes, every command and flag code, walks off the store
    set_root(7'd0);
    load_word(16'h0000, 64'h0);
    load_word(16'hFFFF, '1);
    walk(CMD_READ, 48'h0, 2'd3, 8'h00);
    walk(CMD_READ, 48'h0, 2'd0, 8'h00);
    walk(CMD_UPDATE, 48'h0, 2'd0, {EX_NO_EXECUTE, OP_SET, OP_SET, OP_SET});
    walk(CMD_UPDATE, 48'h0, 2'd1, {EX_EXECUTABLE, OP_CLEAR, OP_CLEAR, OP_CLEAR});
    walk(CMD_UPDATE, 48'h0, 2'd2, {OP_SPARE, OP_SPARE, OP_SPARE, OP_SPARE});
    walk(CMD_UPDATE, 48'h0, 2'd0, {EX_KEEP, OP_KEEP, OP_KEEP, OP_KEEP});
    walk(CMD_READ, 48'h0, 2'd0, {EX_NO_EXECUTE, OP_SET, OP_CLEAR, OP_SET});
    walk(CMD_SPARE, 48'h0, 2'd0, {EX_NO_EXECUTE, OP_SET, OP_SET, OP_SET});
    walk(CMD_READ, 48'hFFFF_FFFF_FFFF, 2'd0, 8'h00);
    set_root(7'd127);
    walk(CMD_READ, 48'hFFFF_FFFF_FFFF, 2'd3, 8'h00);
    // all-ones frame bits lead off the store; no update may happen
    walk(CMD_UPDATE, 48'hFFFF_FFFF_FFFF, 2'd2, {EX_EXECUTABLE, OP_CLEAR, OP_CLEAR, OP_CLEAR});
    walk(CMD_UPDATE, 48'hFFFF_FFFF_FFFF, 2'd0, {EX_EXECUTABLE, OP_CLEAR, OP_CLEAR, OP_CLEAR});
    walk(CMD_READ, 48'hFFFF_FFFF_FFFF, 2'd3, 8'h00);

    // Random phases, each with its own root frame and idling pattern
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        1:       set_root(7'd0);
        2:       set_root(7'd127);
        default: set_root(7'($urandom_range(0, 127)));
      endcase
      idle_pct    = idle_by_phase[p];
      stall_pct   = stall_by_phase[p];
      phase_start = sent;
      while (sent - phase_start < RANDOM_BEATS / PHASES) random_op();
    end

    quiesce();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("four_level_page_table_walker_core_test passed");
    else
      $display("four_level_page_table_walker_core_test failed");
    $finish;
  end

endmodule
